// ----- src/dhd_pkg.sv -----
// Shared types, register indexes and reset values for the detection head decoder.
// No dependencies; every other file in src except dhd_fifo uses this package.
package dhd_pkg;

    localparam int MAX_CLASSES_DEF = 128;
    localparam int JOB_DEPTH_DEF   = 4;
    localparam int RES_DEPTH_DEF   = 4;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_X       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_Y       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_X_SCALE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_SCALE     = 3'd5;

    localparam logic [15:0] THRESHOLD_RST   = 16'd16384;
    localparam logic [7:0]  CLASS_COUNT_RST = 8'd80;
    localparam logic [15:0] PAD_RST         = 16'd0;
    localparam logic [15:0] SCALE_RST       = 16'd4096;

    typedef struct packed {
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [15:0] box_w;
        logic [15:0] box_h;
        logic [15:0] class_score;
    } item_t;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic [15:0]        width;
        logic [15:0]        height;
        logic [6:0]         class_index;
        logic [15:0]        confidence;
    } result_t;

    // One decoded anchor waiting for the box arithmetic.
    typedef struct packed {
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [15:0] box_w;
        logic [15:0] box_h;
        logic [6:0]  class_index;
        logic [15:0] confidence;
    } job_t;

    typedef struct packed {
        logic [15:0] threshold;
        logic [7:0]  class_count;
        logic [15:0] pad_x;
        logic [15:0] pad_y;
        logic [15:0] x_scale;
        logic [15:0] y_scale;
    } cfg_t;

endpackage

// ----- src/detection_head_decode_top.sv -----
// Detection head decoder top level: config registers, front end, job queue, back end,
// result queue. Depends on dhd_pkg, dhd_fifo, dhd_front and dhd_back.
// Throughput: one item per cycle while full is low, one result per cycle while empty is low.
// Path: the result of an anchor passes through the job queue and the multiply stage
// register into the result queue, whose head drives the result ports.
// Reset: asynchronous, active low; queues empty, counters clear, registers to defaults.
module detection_head_decode_top #(
    parameter int MAX_CLASSES = dhd_pkg::MAX_CLASSES_DEF,
    parameter int JOB_DEPTH   = dhd_pkg::JOB_DEPTH_DEF,
    parameter int RES_DEPTH   = dhd_pkg::RES_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // item side
    input  logic                              push,
    output logic                              full,
    input  dhd_pkg::item_t                     item,
    // result side
    output logic                              empty,
    input  logic                              pop,
    output dhd_pkg::result_t                   result,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dhd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [15:0]                       cfg_data
);
    import dhd_pkg::*;

    localparam int JOB_W = $bits(job_t);
    localparam int RES_W = $bits(result_t);

    cfg_t                      cfg_reg, cfg_next;

    logic                      take;
    logic                      job_push, job_pop, job_full, job_empty;
    job_t                      job_w, job_r;
    logic [JOB_W-1:0]          job_rdata;
    logic [$clog2(JOB_DEPTH):0] job_count;

    logic                      res_push, res_pop;
    result_t                   res_w;
    logic [RES_W-1:0]          res_rdata;
    logic [$clog2(RES_DEPTH):0] res_count;

    // Config writes are always accepted; indexes past the list are dropped.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD:   cfg_next.threshold   = cfg_data;
                CFG_CLASS_COUNT: cfg_next.class_count = cfg_data[7:0];
                CFG_PAD_X:       cfg_next.pad_x       = cfg_data;
                CFG_PAD_Y:       cfg_next.pad_y       = cfg_data;
                CFG_X_SCALE:     cfg_next.x_scale     = cfg_data;
                CFG_Y_SCALE:     cfg_next.y_scale     = cfg_data;
                default:         cfg_next             = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold   <= THRESHOLD_RST;
            cfg_reg.class_count <= CLASS_COUNT_RST;
            cfg_reg.pad_x       <= PAD_RST;
            cfg_reg.pad_y       <= PAD_RST;
            cfg_reg.x_scale     <= SCALE_RST;
            cfg_reg.y_scale     <= SCALE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end stalls only on a full job queue; at most one job per item.
    assign full = job_full;
    assign take = push && !full;

    dhd_front #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .take     (take),
        .item     (item),
        .job_push (job_push),
        .job      (job_w)
    );

    dhd_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .wdata (job_w),
        .pop   (job_pop),
        .rdata (job_rdata),
        .full  (job_full),
        .empty (job_empty),
        .count (job_count)
    );

    assign job_r = job_t'(job_rdata);

    dhd_back #(
        .RES_DEPTH (RES_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_empty (job_empty || (job_count == '0)),
        .job       (job_r),
        .job_pop   (job_pop),
        .res_count (res_count),
        .res_push  (res_push),
        .res       (res_w)
    );

    // Result queue: the oldest item sits on the result ports while empty is low.
    assign res_pop = pop && !empty;

    dhd_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_w),
        .pop   (res_pop),
        .rdata (res_rdata),
        .full  (),
        .empty (empty),
        .count (res_count)
    );

    assign result = result_t'(res_rdata);

endmodule

// ----- src/dhd_fifo.sv -----
// Small synchronous queue with registered storage and head-of-queue read.
// Depends on nothing; used for the job queue and the result queue.
module dhd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output logic                       full,
    output logic                       empty,
    output logic [$clog2(DEPTH):0]     count
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rdata   = mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- src/dhd_front.sv -----
// Front end: per-anchor class counter, running top score/class and held box.
// Depends on dhd_pkg; pushes one job per anchor whose top score beats the threshold.
module dhd_front #(
    parameter int MAX_CLASSES = dhd_pkg::MAX_CLASSES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  dhd_pkg::cfg_t  cfg,
    input  logic          take,
    input  dhd_pkg::item_t item,
    output logic          job_push,
    output dhd_pkg::job_t  job
);
    import dhd_pkg::*;

    localparam int CNT_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam logic [8:0] MAX_N = 9'(MAX_CLASSES);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [15:0]      top_score_reg, top_score_next;
    logic [CNT_W-1:0] top_class_reg, top_class_next;
    logic [15:0]      cx_reg, cy_reg, bw_reg, bh_reg;

    logic             first;
    logic             last;
    logic [8:0]       n_eff;
    logic [15:0]      base_score;
    logic [CNT_W-1:0] base_class;
    logic [15:0]      cx, cy, bw, bh;

    // Class count clamped to 1..MAX_CLASSES.
    always_comb
    begin
        if (cfg.class_count == '0)
        begin
            n_eff = 9'd1;
        end
        else if ({1'b0, cfg.class_count} > MAX_N)
        begin
            n_eff = MAX_N;
        end
        else
        begin
            n_eff = {1'b0, cfg.class_count};
        end
    end

    assign first      = (cnt_reg == '0);
    assign last       = (9'(cnt_reg) + 9'd1) >= n_eff;
    assign base_score = first ? 16'd0 : top_score_reg;
    assign base_class = first ? '0 : top_class_reg;
    assign cx         = first ? item.center_x : cx_reg;
    assign cy         = first ? item.center_y : cy_reg;
    assign bw         = first ? item.box_w    : bw_reg;
    assign bh         = first ? item.box_h    : bh_reg;

    always_comb
    begin
        // strict compare: earliest class keeps a tie
        if (item.class_score > base_score)
        begin
            top_score_next = item.class_score;
            top_class_next = cnt_reg;
        end
        else
        begin
            top_score_next = base_score;
            top_class_next = base_class;
        end
        cnt_next = last ? '0 : cnt_reg + 1'b1;
    end

    assign job_push        = take && last && (top_score_next > cfg.threshold);
    assign job.center_x    = cx;
    assign job.center_y    = cy;
    assign job.box_w       = bw;
    assign job.box_h       = bh;
    assign job.class_index = 7'(top_class_next);
    assign job.confidence  = top_score_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            top_score_reg <= '0;
            top_class_reg <= '0;
        end
        else if (take)
        begin
            cnt_reg       <= cnt_next;
            top_score_reg <= top_score_next;
            top_class_reg <= top_class_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && first)
        begin
            cx_reg <= item.center_x;
            cy_reg <= item.center_y;
            bw_reg <= item.box_w;
            bh_reg <= item.box_h;
        end
    end

endmodule

// ----- src/dhd_back.sv -----
// Back end: padding removal, scaling, truncation and saturation of one box per job.
// Depends on dhd_pkg; a multiply stage, then truncation and saturation into the result queue.
module dhd_back #(
    parameter int RES_DEPTH = dhd_pkg::RES_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dhd_pkg::cfg_t                  cfg,
    input  logic                          job_empty,
    input  dhd_pkg::job_t                  job,
    output logic                          job_pop,
    input  logic [$clog2(RES_DEPTH):0]    res_count,
    output logic                          res_push,
    output dhd_pkg::result_t               res
);
    import dhd_pkg::*;

    localparam int CW = $clog2(RES_DEPTH) + 1;

    logic signed [36:0] px_reg, py_reg;
    logic [31:0]        wx_reg, wy_reg;
    logic [6:0]         cls_reg;
    logic [15:0]        conf_reg;
    logic               s1_valid_reg, s1_valid_next;

    logic [CW:0]        occ;
    logic               credit;
    logic signed [19:0] dx, dy;
    logic signed [16:0] sx, sy;

    // Value at scale 2^17 -> integer, toward zero, saturated to 16 bits signed.
    function automatic logic signed [15:0] edge_sat(input logic signed [36:0] p);
        logic signed [36:0] adj;
        logic signed [19:0] q;
        adj = p + (p[36] ? 37'sd131071 : 37'sd0);
        q   = 20'(adj >>> 17);
        if (q > 20'sd32767)
        begin
            edge_sat = 16'sh7FFF;
        end
        else if (q < -20'sd32768)
        begin
            edge_sat = 16'sh8000;
        end
        else
        begin
            edge_sat = 16'(q);
        end
    endfunction

    // Room in the result queue counts the job already in the multiply stage.
    assign occ           = {1'b0, res_count} + {{CW{1'b0}}, s1_valid_reg};
    assign credit        = occ < (CW+1)'(RES_DEPTH);
    assign job_pop       = !job_empty && credit;
    assign s1_valid_next = job_pop;

    // Edge offsets in 1/32 pixel: 2*c - 2*pad - size.
    assign dx = $signed({3'b0, job.center_x, 1'b0}) - $signed({3'b0, cfg.pad_x, 1'b0})
              - $signed({4'b0, job.box_w});
    assign dy = $signed({3'b0, job.center_y, 1'b0}) - $signed({3'b0, cfg.pad_y, 1'b0})
              - $signed({4'b0, job.box_h});
    assign sx = $signed({1'b0, cfg.x_scale});
    assign sy = $signed({1'b0, cfg.y_scale});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Operands are extended to the full product width before the multiply.
    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            px_reg   <= 37'(dx) * 37'(sx);
            py_reg   <= 37'(dy) * 37'(sy);
            wx_reg   <= 32'(job.box_w) * 32'(cfg.x_scale);
            wy_reg   <= 32'(job.box_h) * 32'(cfg.y_scale);
            cls_reg  <= job.class_index;
            conf_reg <= job.confidence;
        end
    end

    // Size products never exceed 16 bits after the shift, so no clamp there.
    assign res_push        = s1_valid_reg;
    assign res.left        = edge_sat(px_reg);
    assign res.top         = edge_sat(py_reg);
    assign res.width       = wx_reg[31:16];
    assign res.height      = wy_reg[31:16];
    assign res.class_index = cls_reg;
    assign res.confidence  = conf_reg;

endmodule

// ----- src/dhd_checker.sv -----
// Port-level checks for the detection head decoder, bound to the top level.
// Depends on dhd_pkg and detection_head_decode_top.
module dhd_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             full,
    input logic             empty,
    input logic             pop,
    input dhd_pkg::result_t  result,
    input logic             cfg_valid,
    input logic             cfg_ready
);
    // A waiting result item is neither dropped nor changed until popped.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result item changed or vanished while not popped");

    // Only anchors above the threshold are emitted, so confidence is never zero.
    a_conf_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.confidence != 16'd0))
        else $error("result item with zero confidence");

    // The job queue backs up only when the result queue holds items.
    a_full_has_results: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("input stalled while no result is waiting");

    // Configuration writes are never back-pressured.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind detection_head_decode_top dhd_checker u_dhd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
